### design/chm_pkg.sv
// shared types and constants of the cyclic hamming code matcher
package chm_pkg;

    localparam int DEF_MAX_REFERENCES   = 16;
    localparam int DEF_MAX_PATTERN_BITS = 31;

    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int INDEX_W     = 4;
    localparam int CODE_W      = 31;
    localparam int LENGTH_W    = 6;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 8;
    localparam int GROUP_BITS  = 8;
    localparam int GROUP_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIT_ERRORS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] PATTERN_LENGTH_RESET = 5'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

    typedef struct packed {
        logic adv2;
        logic adv3;
    } pipe_ctl_t;

    typedef struct packed {
        logic empty;
        logic too_short;
    } early_t;

endpackage

### design/chm_table.sv
// reference code table, one flop row per slot, written by load requests
module chm_table #(
    parameter int DEPTH = chm_pkg::DEF_MAX_REFERENCES,
    parameter int W     = chm_pkg::DEF_MAX_PATTERN_BITS
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [chm_pkg::INDEX_W-1:0]  widx,
    input  logic [W-1:0]                 wdata,
    output logic [W-1:0]                 entries [DEPTH]
);
    import chm_pkg::*;

    logic [W-1:0] table_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            if (we && (32'(widx) == k))
            begin
                table_reg[k] <= wdata;
            end
        end
    end

    assign entries = table_reg;

endmodule

### design/chm_ref_cmp.sv
// all rotations of one reference against the window: partial counts, then hit flag
module chm_ref_cmp #(
    parameter int W = chm_pkg::DEF_MAX_PATTERN_BITS
) (
    input  logic                        clk,
    input  chm_pkg::pipe_ctl_t          ctl,
    input  logic [W-1:0]                code,
    input  logic [W-1:0]                mask,
    input  logic [W-1:0]                window,
    input  logic [chm_pkg::CFG_W-1:0]   len,
    input  logic [chm_pkg::CFG_W-1:0]   max_err,
    input  logic                        ref_en,
    output logic                        hit
);
    import chm_pkg::*;

    localparam int NGROUP = (W + GROUP_BITS - 1) / GROUP_BITS;
    localparam int CW     = $clog2(W + 1);

    logic [W-1:0]             code_m;
    logic [2*W-1:0]           doubled;
    logic [W-1:0]             lane_hit;
    logic                     hit_next;
    logic                     hit_reg;

    assign code_m  = code & mask;
    assign doubled = {{W{1'b0}}, code_m} | ({{W{1'b0}}, code_m} << len);

    for (genvar r = 0; r < W; r++)
    begin : g_rot
        logic [W-1:0] rot;
        logic [W-1:0] diff;
        logic [GROUP_CNT_W-1:0] pc_next [NGROUP];
        logic [GROUP_CNT_W-1:0] pc_reg  [NGROUP];
        logic [CW-1:0] sum;

        assign rot  = W'(doubled >> r) & mask;
        assign diff = rot ^ window;

        always_comb
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                pc_next[g] = '0;
                for (int b = 0; b < GROUP_BITS; b++)
                begin
                    if (g * GROUP_BITS + b < W)
                    begin
                        pc_next[g] = pc_next[g]
                                   + GROUP_CNT_W'(diff[g * GROUP_BITS + b]);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv2)
            begin
                pc_reg <= pc_next;
            end
        end

        always_comb
        begin
            sum = '0;
            for (int g = 0; g < NGROUP; g++)
            begin
                sum = sum + CW'(pc_reg[g]);
            end
        end

        assign lane_hit[r] = (r < 32'(len)) && (32'(sum) <= 32'(max_err));
    end

    assign hit_next = ref_en && (|lane_hit);

    always_ff @(posedge clk)
    begin
        if (ctl.adv3)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

### design/chm_resolve.sv
// lowest matching reference and result register
module chm_resolve #(
    parameter int DEPTH = chm_pkg::DEF_MAX_REFERENCES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  chm_pkg::early_t               early,
    input  logic [DEPTH-1:0]              hits,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [chm_pkg::STATUS_W-1:0]  status,
    output logic [chm_pkg::INDEX_W-1:0]   index
);
    import chm_pkg::*;

    logic                 any_hit;
    logic [INDEX_W-1:0]   first_idx;
    logic [STATUS_W-1:0]  status_next;
    logic [INDEX_W-1:0]   index_next;
    logic                 valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic                 adv;

    always_comb
    begin
        any_hit   = 1'b0;
        first_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (hits[k])
            begin
                any_hit   = 1'b1;
                first_idx = INDEX_W'(k);
            end
        end
    end

    always_comb
    begin
        status_next = STATUS_NONE;
        index_next  = '0;
        if (early.empty)
        begin
            status_next = STATUS_NONE;
        end
        else if (early.too_short)
        begin
            status_next = STATUS_SHORT;
        end
        else if (any_hit)
        begin
            status_next = STATUS_MATCH;
            index_next  = first_idx;
        end
    end

    assign adv = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;

endmodule

### design/cyclic_hamming_code_matcher.sv
// top level of the cyclic hamming code matcher
//
// requests enter on the s_axis channel: tuser 0 loads ref_pattern into slot
// ref_index, tuser 1 matches signal_bits/signal_length against every cyclic
// rotation of the first reference_count stored codes. a load request gives
// no result; a match request gives one result on m_axis (tuser status,
// tdata match index). configuration is written through cfg_we/cfg_index/
// cfg_data while no request is in flight.
//
// the pipeline has four register stages: input register, per-rotation
// partial popcounts, per-reference hit flags, result register. a new
// request is taken every cycle while the receiver keeps up; all rotations
// of all slots are compared in parallel lanes.
//
// each stage holds its request while the stage after it is full, so a
// stalled receiver backs the pipeline up without loss and bubbles close
// up. reset empties the pipeline and restores the register defaults; the
// table slots hold no value until loaded.
module cyclic_hamming_code_matcher #(
    parameter int MAX_REFERENCES   = chm_pkg::DEF_MAX_REFERENCES,
    parameter int MAX_PATTERN_BITS = chm_pkg::DEF_MAX_PATTERN_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // ref_index, ref_pattern, signal_bits, signal_length
    input  logic [chm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // match_index, zero fill
    output logic [chm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // match_status
    output logic [chm_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                            cfg_we,
    input  logic [chm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chm_pkg::CFG_W-1:0]       cfg_data
);
    import chm_pkg::*;

    localparam int W = MAX_PATTERN_BITS;

    logic [CFG_W-1:0]     pattern_length_reg;
    logic [CFG_W-1:0]     max_bit_errors_reg;
    logic [CFG_W-1:0]     reference_count_reg;

    logic                 s1_valid_reg;
    logic                 s1_type_reg;
    logic [INDEX_W-1:0]   s1_index_reg;
    logic [CODE_W-1:0]    s1_pattern_reg;
    logic [CODE_W-1:0]    s1_signal_reg;
    logic [LENGTH_W-1:0]  s1_length_reg;
    logic                 s2_valid_reg;
    early_t               s2_early_reg;
    logic                 s3_valid_reg;
    early_t               s3_early_reg;

    pipe_ctl_t            ctl;
    logic                 adv1;
    logic                 adv4;
    logic                 table_we;
    early_t               s2_early_next;
    logic [CFG_W-1:0]     len;
    logic [W-1:0]         mask;
    logic [W-1:0]         window;
    logic [W-1:0]         entries [MAX_REFERENCES];
    logic [MAX_REFERENCES-1:0] hits;
    logic [STATUS_W-1:0]  res_status;
    logic [INDEX_W-1:0]   res_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg  <= PATTERN_LENGTH_RESET;
            max_bit_errors_reg  <= '0;
            reference_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_data;
                CFG_MAX_BIT_ERRORS:  max_bit_errors_reg  <= cfg_data;
                CFG_REFERENCE_COUNT: reference_count_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // stage handshakes
    assign adv4     = !m_axis_tvalid || m_axis_tready;
    assign ctl.adv3 = !s3_valid_reg || adv4;
    assign ctl.adv2 = !s2_valid_reg || ctl.adv3;
    assign adv1     = !s1_valid_reg || ctl.adv2;
    assign s_axis_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (ctl.adv2)
            begin
                s2_valid_reg <= s1_valid_reg && (s1_type_reg == REQ_MATCH);
            end
            if (ctl.adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_type_reg    <= s_axis_tuser;
            s1_index_reg   <= s_axis_tdata[3:0];
            s1_pattern_reg <= s_axis_tdata[34:4];
            s1_signal_reg  <= s_axis_tdata[65:35];
            s1_length_reg  <= s_axis_tdata[71:66];
        end
        if (ctl.adv2)
        begin
            s2_early_reg <= s2_early_next;
        end
        if (ctl.adv3)
        begin
            s3_early_reg <= s2_early_reg;
        end
    end

    // loads write as they leave the first stage, so matches see them in order
    assign table_we = s1_valid_reg && (s1_type_reg == REQ_LOAD) && ctl.adv2;

    chm_table #(
        .DEPTH (MAX_REFERENCES),
        .W     (W)
    ) u_table (
        .clk     (clk),
        .we      (table_we),
        .widx    (s1_index_reg),
        .wdata   (s1_pattern_reg[W-1:0]),
        .entries (entries)
    );

    assign len = (32'(pattern_length_reg) > W) ? CFG_W'(W) : pattern_length_reg;

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            mask[i] = (i < 32'(len));
        end
    end

    assign window = s1_signal_reg[W-1:0] & mask;

    assign s2_early_next.empty     = (s1_length_reg == '0);
    assign s2_early_next.too_short = (s1_length_reg < LENGTH_W'(pattern_length_reg));

    for (genvar k = 0; k < MAX_REFERENCES; k++)
    begin : g_ref
        chm_ref_cmp #(
            .W (W)
        ) u_ref_cmp (
            .clk     (clk),
            .ctl     (ctl),
            .code    (entries[k]),
            .mask    (mask),
            .window  (window),
            .len     (len),
            .max_err (max_bit_errors_reg),
            .ref_en  (k < 32'(reference_count_reg)),
            .hit     (hits[k])
        );
    end

    chm_resolve #(
        .DEPTH (MAX_REFERENCES)
    ) u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .early     (s3_early_reg),
        .hits      (hits),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .status    (res_status),
        .index     (res_index)
    );

    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {{(OUT_DATA_W - INDEX_W){1'b0}}, res_index};

`ifndef NO_ASSERTIONS
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_type_reg == REQ_LOAD) && ctl.adv2) |=> !s2_valid_reg)
        else $error("load request reached the compare stage");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STATUS_MATCH)) |-> (m_axis_tdata == '0))
        else $error("nonzero index on a result without a match");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == STATUS_MATCH) || (m_axis_tuser == STATUS_NONE)
                          || (m_axis_tuser == STATUS_SHORT)))
        else $error("undefined result status");

    a_stage3_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !ctl.adv3) |=> (s3_valid_reg && $stable(s3_early_reg)))
        else $error("stalled stage three request changed or vanished");
`endif

endmodule

### tb/cyclic_hamming_code_matcher_tb.sv
// testbench for the cyclic hamming code matcher: directed and random requests checked in order
`timescale 1ns / 1ps

module cyclic_hamming_code_matcher_tb;

    import chm_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
    } match_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    logic [CFG_W-1:0]        cur_pattern_length;
    logic [CFG_W-1:0]        cur_max_bit_errors;
    logic [CFG_W-1:0]        cur_reference_count;
    logic [CODE_W-1:0]       code_table [DEF_MAX_REFERENCES];
    match_result_t           pending_results [$];

    int                      error_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      hold_requests = 0;
    int                      hold_served;
    int                      hold_left;

    cyclic_hamming_code_matcher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // low plen bits of code rotated right by r within those bits
    function automatic logic [CODE_W-1:0] rotate_code(logic [CODE_W-1:0] code, int plen, int r);
        logic [63:0] mask;
        logic [63:0] doubled;
        mask = (64'd1 << plen) - 64'd1;
        doubled = (64'(code) & mask) | ((64'(code) & mask) << plen);
        return CODE_W'((doubled >> r) & mask);
    endfunction

    function automatic int searched_count();
        return (cur_reference_count > DEF_MAX_REFERENCES) ? DEF_MAX_REFERENCES
                                                          : int'(cur_reference_count);
    endfunction

    function automatic match_result_t predict_match(logic [CODE_W-1:0] bits,
                                                    logic [LENGTH_W-1:0] length);
        match_result_t res;
        int plen;
        logic [CODE_W-1:0] mask;
        logic [CODE_W-1:0] window;
        res.status = STATUS_NONE;
        res.index = '0;
        if (length == 0)
            return res;
        if (length < cur_pattern_length)
        begin
            res.status = STATUS_SHORT;
            return res;
        end
        plen = (cur_pattern_length > DEF_MAX_PATTERN_BITS) ? DEF_MAX_PATTERN_BITS
                                                          : int'(cur_pattern_length);
        mask = CODE_W'((64'd1 << plen) - 64'd1);
        window = bits & mask;
        for (int k = 0; k < searched_count(); k++)
        begin
            for (int r = 0; r < plen; r++)
            begin
                if ($countones(rotate_code(code_table[k], plen, r) ^ window)
                        <= cur_max_bit_errors)
                begin
                    res.status = STATUS_MATCH;
                    res.index = INDEX_W'(k);
                    return res;
                end
            end
        end
        return res;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_served <= 0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            m_axis_tready <= 1'b0;
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        match_result_t expected;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                expected = pending_results.pop_front();
                if (m_axis_tuser !== expected.status)
                begin
                    $display("%0t: match_status mismatch: expected %0d actual %0d",
                             $time, expected.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== OUT_DATA_W'(expected.index))
                begin
                    $display("%0t: match_index mismatch: expected %h actual %h",
                             $time, OUT_DATA_W'(expected.index), m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic kind, input logic [INDEX_W-1:0] slot,
                                input logic [CODE_W-1:0] pattern,
                                input logic [CODE_W-1:0] bits,
                                input logic [LENGTH_W-1:0] length);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {length, bits, pattern, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == REQ_LOAD)
            code_table[slot] = pattern;
        else
            pending_results = {pending_results, predict_match(bits, length)};
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] slot, input logic [CODE_W-1:0] pattern);
        send_request(REQ_LOAD, slot, pattern, CODE_W'($urandom()), LENGTH_W'($urandom()));
    endtask

    task automatic send_match(input logic [CODE_W-1:0] bits, input logic [LENGTH_W-1:0] length);
        send_request(REQ_MATCH, INDEX_W'($urandom()), CODE_W'($urandom()), bits, length);
    endtask

    // observed window built from a stored code: rotated, a few bits flipped
    task automatic send_near_match();
        int plen;
        int flips;
        int k;
        logic [CODE_W-1:0] bits;
        logic [CODE_W-1:0] mask;
        plen = int'(cur_pattern_length);
        if (plen == 0 || searched_count() == 0)
        begin
            send_match(CODE_W'($urandom()), LENGTH_W'($urandom()));
            return;
        end
        mask = CODE_W'((64'd1 << plen) - 64'd1);
        k = $urandom_range(searched_count() - 1);
        bits = rotate_code(code_table[k], plen, $urandom_range(plen - 1));
        flips = $urandom_range((cur_max_bit_errors + 1 < plen) ? cur_max_bit_errors + 1 : plen);
        repeat (flips)
        begin
            int pos;
            pos = $urandom_range(plen - 1);
            bits[pos] = ~bits[pos];
        end
        bits = bits | (CODE_W'($urandom()) & ~mask);
        send_match(bits, LENGTH_W'($urandom_range(63, plen)));
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] plen, input logic [CFG_W-1:0] max_err,
                              input logic [CFG_W-1:0] count);
        wait_for_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data <= plen;
        @(posedge clk);
        cfg_index <= CFG_MAX_BIT_ERRORS;
        cfg_data <= max_err;
        @(posedge clk);
        cfg_index <= CFG_REFERENCE_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_pattern_length = plen;
        cur_max_bit_errors = max_err;
        cur_reference_count = count;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    // empty table, reset register values
    task automatic test_reset_defaults();
        send_match('0, 6'd0);
        send_match(31'h7FFF_FFFF, 6'd3);
        send_match(31'h7FFF_FFFF, 6'd63);
    endtask

    task automatic test_load_table();
        send_load(4'd0, '0);
        for (int i = 1; i < DEF_MAX_REFERENCES - 1; i++)
            send_load(INDEX_W'(i), CODE_W'($urandom()));
        send_load(4'd15, 31'h7FFF_FFFF);
    endtask

    task automatic test_special_cases();
        set_config(5'd8, 5'd0, 5'd16);
        send_match(rotate_code(code_table[3], 8, 5) | 31'h7FFF_FF00, 6'd8);
        send_match(31'h0000_00FF, 6'd63);
        send_match(31'h0000_0055, 6'd7);
        set_config(5'd0, 5'd31, 5'd16);
        send_match(31'h7FFF_FFFF, 6'd1);
        set_config(5'd31, 5'd31, 5'd31);
        send_match(31'h1234_5678, 6'd31);
        set_config(5'd31, 5'd0, 5'd17);
        send_match(31'h7FFF_FFFF, 6'd31);
        send_match(31'h5555_5555, 6'd30);
    endtask

    task automatic test_backpressure();
        set_idling(0);
        set_config(5'd12, 5'd2, 5'd16);
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_near_match();
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        for (int i = 0; i < 20; i++)
            send_near_match();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_config(5'd31, 5'd31, 5'd16);
                1: set_config(5'd1, 5'd0, 5'd1);
                2: set_config(5'd0, 5'd5, 5'd16);
                3: set_config(5'd31, 5'd0, 5'd31);
                4: set_config(5'd16, 5'd3, 5'd0);
                default: set_config(CFG_W'($urandom_range(31, 1)), CFG_W'($urandom_range(4)),
                                    CFG_W'($urandom_range(16, 1)));
            endcase
            set_idling(p);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 10)
                    send_load(INDEX_W'($urandom()), CODE_W'($urandom()));
                else if (pick < 70)
                    send_near_match();
                else if (pick < 80)
                    send_match(CODE_W'($urandom()),
                               LENGTH_W'($urandom_range(cur_pattern_length)));
                else
                    send_match(CODE_W'($urandom()), LENGTH_W'($urandom()));
                if (i % 50 == 49 && $urandom_range(2) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_for_results();
                end
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_LOAD;
        cfg_we <= 1'b0;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data <= '0;
        cur_pattern_length = PATTERN_LENGTH_RESET;
        cur_max_bit_errors = '0;
        cur_reference_count = '0;
        foreach (code_table[i])
            code_table[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_load_table();
        test_special_cases();
        test_backpressure();
        test_random_traffic();

        wait_for_idle();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
